>>> sv/rsnp_pkg.sv
package rsnp_pkg;

  localparam int MaxSpheresDef = 1024;

  // Configuration port
  localparam int AddrW = 3;
  localparam int DataW = 32;
  localparam logic AddrSelEn   = 1'b0;
  localparam logic AddrMaxDist = 1'b1;

  // Item modes
  localparam logic [1:0] ModeOrigin = 2'd0;
  localparam logic [1:0] ModeDir    = 2'd1;
  localparam logic [1:0] ModeSphere = 2'd2;

  localparam logic [30:0] DistSat = 31'h7FFF_FFFF;

  // Sequencer lengths
  localparam int NumUops   = 26;
  localparam int SqrtIters = 64;
  localparam int DivIters  = 31;
  localparam int CtrCntW   = 6;
  localparam int StepW     = 5;

  // The accumulator holds a*r*r minus three 128-bit squares.
  localparam int AccW = 131;

  typedef enum logic [4:0] {
    OpD0, OpD1, OpD2, OpW0, OpW1, OpW2, OpR,
    OpALo, OpAHi, OpRLo, OpRHi,
    OpC0Lo, OpC0Hi, OpC1Lo, OpC1Hi, OpC2Lo, OpC2Hi
  } opnd_e;

  typedef enum logic [1:0] {Sh0, Sh32, Sh33, Sh64} shift_e;

  typedef enum logic [2:0] {DstNone, DstA, DstRr, DstC0, DstC1, DstC2, DstB} dest_e;

  typedef struct packed {
    opnd_e  opa;
    opnd_e  opb;
    shift_e sh;
    logic   neg;
    logic   first;
    dest_e  dst;
  } uop_t;

  typedef struct packed {
    logic             accept;
    logic             mul_issue;
    logic [StepW-1:0] step;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             root;
    logic             div_step;
    logic             book;
    logic             finish;
  } cmd_t;

  typedef struct packed {
    logic needs_solve;
    logic last;
    logic out_busy;
  } sts_t;

  // Multiply-accumulate program for one sphere: a = d.d, r*r, the three
  // cross product terms, b = w.d, then a*r*r minus the squared cross terms.
  function automatic uop_t uop_at(input logic [StepW-1:0] step);
    uop_t u;
    case (step)
      5'd0:  u = '{OpD0,   OpD0,   Sh0,  1'b0, 1'b1, DstNone};
      5'd1:  u = '{OpD1,   OpD1,   Sh0,  1'b0, 1'b0, DstNone};
      5'd2:  u = '{OpD2,   OpD2,   Sh0,  1'b0, 1'b0, DstA};
      5'd3:  u = '{OpR,    OpR,    Sh0,  1'b0, 1'b1, DstRr};
      5'd4:  u = '{OpW1,   OpD2,   Sh0,  1'b0, 1'b1, DstNone};
      5'd5:  u = '{OpW2,   OpD1,   Sh0,  1'b1, 1'b0, DstC0};
      5'd6:  u = '{OpW2,   OpD0,   Sh0,  1'b0, 1'b1, DstNone};
      5'd7:  u = '{OpW0,   OpD2,   Sh0,  1'b1, 1'b0, DstC1};
      5'd8:  u = '{OpW0,   OpD1,   Sh0,  1'b0, 1'b1, DstNone};
      5'd9:  u = '{OpW1,   OpD0,   Sh0,  1'b1, 1'b0, DstC2};
      5'd10: u = '{OpW0,   OpD0,   Sh0,  1'b0, 1'b1, DstNone};
      5'd11: u = '{OpW1,   OpD1,   Sh0,  1'b0, 1'b0, DstNone};
      5'd12: u = '{OpW2,   OpD2,   Sh0,  1'b0, 1'b0, DstB};
      5'd13: u = '{OpALo,  OpRLo,  Sh0,  1'b0, 1'b1, DstNone};
      5'd14: u = '{OpALo,  OpRHi,  Sh32, 1'b0, 1'b0, DstNone};
      5'd15: u = '{OpAHi,  OpRLo,  Sh32, 1'b0, 1'b0, DstNone};
      5'd16: u = '{OpAHi,  OpRHi,  Sh64, 1'b0, 1'b0, DstNone};
      5'd17: u = '{OpC0Lo, OpC0Lo, Sh0,  1'b1, 1'b0, DstNone};
      5'd18: u = '{OpC0Lo, OpC0Hi, Sh33, 1'b1, 1'b0, DstNone};
      5'd19: u = '{OpC0Hi, OpC0Hi, Sh64, 1'b1, 1'b0, DstNone};
      5'd20: u = '{OpC1Lo, OpC1Lo, Sh0,  1'b1, 1'b0, DstNone};
      5'd21: u = '{OpC1Lo, OpC1Hi, Sh33, 1'b1, 1'b0, DstNone};
      5'd22: u = '{OpC1Hi, OpC1Hi, Sh64, 1'b1, 1'b0, DstNone};
      5'd23: u = '{OpC2Lo, OpC2Lo, Sh0,  1'b1, 1'b0, DstNone};
      5'd24: u = '{OpC2Lo, OpC2Hi, Sh33, 1'b1, 1'b0, DstNone};
      5'd25: u = '{OpC2Hi, OpC2Hi, Sh64, 1'b1, 1'b0, DstNone};
      default: u = '{OpD0, OpD0, Sh0, 1'b0, 1'b0, DstNone};
    endcase
    return u;
  endfunction

endpackage

>>> sv/rsnp_item_if.sv
interface rsnp_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic [30:0]        radius;
  logic               eligible;
  logic               last;

  modport source (output valid, mode, vec_x, vec_y, vec_z, radius, eligible, last,
                  input ready);
  modport sink (input valid, mode, vec_x, vec_y, vec_z, radius, eligible, last,
                output ready);
endinterface

>>> sv/rsnp_res_if.sv
interface rsnp_res_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [9:0]  hit_index;
  logic [30:0] distance;
  logic        selection_changed;
  logic        overflow;

  modport source (output valid, hit, hit_index, distance, selection_changed, overflow,
                  input ready);
  modport sink (input valid, hit, hit_index, distance, selection_changed, overflow,
                output ready);
endinterface

>>> sv/ray_sphere_nearest_pick.sv
// A result is valid once a last item is booked and the finish step has written the output
// register, later while the previous result still waits.
// One item at a time: loads and skipped spheres go from the check straight to booking,
// eligible spheres solve first, and a last item waits for the finish step. An eligible
// sphere: 26 multiplies on one 33x33 multiplier, 64 two-bit root steps, 31 divide steps.
// Reset is asynchronous, active low: ray, pick and selection state clear, selection enabled.
module ray_sphere_nearest_pick #(
  parameter int MAX_SPHERES = rsnp_pkg::MaxSpheresDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rsnp_pkg::AddrW-1:0] paddr,
  input  logic [rsnp_pkg::DataW-1:0] pwdata,
  output logic [rsnp_pkg::DataW-1:0] prdata,
  output logic                       pready,
  rsnp_item_if.sink                  item_i,
  rsnp_res_if.source                 res_o
);
  import rsnp_pkg::*;

  logic        sel_en_q;
  logic [30:0] max_dist_q;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_en_q   <= 1'b1;
      max_dist_q <= DistSat;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        AddrSelEn:   sel_en_q   <= pwdata[0];
        AddrMaxDist: max_dist_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      AddrSelEn:   prdata = {31'd0, sel_en_q};
      AddrMaxDist: prdata = {1'b0, max_dist_q};
      default:     prdata = '0;
    endcase
  end

  rsnp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rsnp_dp #(
    .MAX_SPHERES (MAX_SPHERES)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .mode_i              (item_i.mode),
    .vec_x_i             (item_i.vec_x),
    .vec_y_i             (item_i.vec_y),
    .vec_z_i             (item_i.vec_z),
    .radius_i            (item_i.radius),
    .eligible_i          (item_i.eligible),
    .last_i              (item_i.last),
    .sel_en_i            (sel_en_q),
    .max_dist_i          (max_dist_q),
    .res_valid_o         (res_o.valid),
    .res_ready_i         (res_o.ready),
    .hit_o               (res_o.hit),
    .hit_index_o         (res_o.hit_index),
    .distance_o          (res_o.distance),
    .selection_changed_o (res_o.selection_changed),
    .overflow_o          (res_o.overflow)
  );

endmodule

>>> sv/rsnp_ctrl.sv
module rsnp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rsnp_pkg::sts_t sts_i,
  output rsnp_pkg::cmd_t cmd_o
);
  import rsnp_pkg::*;

  typedef enum logic [9:0] {
    StIdle   = 10'b00_0000_0001,
    StCheck  = 10'b00_0000_0010,
    StMul    = 10'b00_0000_0100,
    StMulW   = 10'b00_0000_1000,
    StSqInit = 10'b00_0001_0000,
    StSqrt   = 10'b00_0010_0000,
    StRoot   = 10'b00_0100_0000,
    StDiv    = 10'b00_1000_0000,
    StBook   = 10'b01_0000_0000,
    StFin    = 10'b10_0000_0000
  } state_e;

  state_e             state_q, state_d;
  logic [CtrCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StCheck;
        end
      end
      StCheck: begin
        cnt_d = '0;
        if (sts_i.needs_solve) begin
          state_d = StMul;
        end else begin
          state_d = StBook;
        end
      end
      StMul: begin
        cmd_o.mul_issue = 1'b1;
        cmd_o.step      = cnt_q[StepW-1:0];
        if (cnt_q == CtrCntW'(NumUops - 1)) begin
          state_d = StMulW;
        end else begin
          cnt_d = cnt_q + CtrCntW'(1);
        end
      end
      StMulW: begin
        state_d = StSqInit;
      end
      StSqInit: begin
        cmd_o.sqrt_init = 1'b1;
        cnt_d           = '0;
        state_d         = StSqrt;
      end
      StSqrt: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_q == CtrCntW'(SqrtIters - 1)) begin
          state_d = StRoot;
        end else begin
          cnt_d = cnt_q + CtrCntW'(1);
        end
      end
      StRoot: begin
        cmd_o.root = 1'b1;
        cnt_d      = '0;
        state_d    = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CtrCntW'(DivIters - 1)) begin
          state_d = StBook;
        end else begin
          cnt_d = cnt_q + CtrCntW'(1);
        end
      end
      StBook: begin
        cmd_o.book = 1'b1;
        state_d    = sts_i.last ? StFin : StIdle;
      end
      StFin: begin
        // Hold the pick result until the output register is free.
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> sv/rsnp_dp.sv
module rsnp_dp #(
  parameter int MAX_SPHERES = rsnp_pkg::MaxSpheresDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rsnp_pkg::cmd_t     cmd_i,
  output rsnp_pkg::sts_t     sts_o,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic [30:0]        radius_i,
  input  logic               eligible_i,
  input  logic               last_i,
  input  logic               sel_en_i,
  input  logic [30:0]        max_dist_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic               hit_o,
  output logic [9:0]         hit_index_o,
  output logic [30:0]        distance_o,
  output logic               selection_changed_o,
  output logic               overflow_o
);
  import rsnp_pkg::*;

  localparam int IdxW    = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int SphCntW = $clog2(MAX_SPHERES + 1);

  // Ray and item registers
  logic signed [31:0] origin_q [3];
  logic signed [31:0] dir_q [3];
  logic signed [31:0] vec_in [3];
  logic signed [32:0] w_q [3];
  logic [1:0]         mode_q;
  logic [30:0]        radius_q;
  logic               elig_q;
  logic               last_q;

  // Multiply-accumulate
  uop_t               uop_cur, uop_q;
  logic signed [32:0] opa, opb;
  logic signed [65:0] prod_q;
  logic               pvld_q;
  logic signed [AccW-1:0] ext, term, acc_d, acc_q;
  logic [63:0]        a_q, rr_q;
  logic signed [64:0] c_q [3];
  logic signed [65:0] b_q;

  // Square root and division
  logic [127:0] rad_q;
  logic [65:0]  rem_q;
  logic [63:0]  root_q;
  logic [67:0]  sq_tmp, sq_trial;
  logic         sq_ge;
  logic         miss_q, sat_q;
  logic [66:0]  n1, n2, nsel;
  logic         pos1, pos2;
  logic [65:0]  n_u;
  logic [63:0]  drem_q;
  logic [30:0]  dsh_q, quo_q;
  logic [64:0]  dv_tmp, dv_a;
  logic         dv_ge;
  logic [30:0]  sph_dist;

  // Pick and selection state
  logic [31:0]        best_q;
  logic [IdxW-1:0]    best_idx_q, sel_idx_q;
  logic               found_q, ovf_q, sel_valid_q;
  logic [SphCntW-1:0] cnt_q;
  logic               cnt_full;
  logic               fin_hit, fin_chg;

  assign vec_in[0] = vec_x_i;
  assign vec_in[1] = vec_y_i;
  assign vec_in[2] = vec_z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        origin_q[i] <= '0;
        dir_q[i]    <= '0;
      end
    end else if (cmd_i.accept) begin
      for (int i = 0; i < 3; i++) begin
        if (mode_i == ModeOrigin) origin_q[i] <= vec_in[i];
        if (mode_i == ModeDir) dir_q[i] <= vec_in[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q   <= mode_i;
      radius_q <= radius_i;
      elig_q   <= eligible_i;
      last_q   <= last_i;
      for (int i = 0; i < 3; i++) begin
        w_q[i] <= {vec_in[i][31], vec_in[i]} - {origin_q[i][31], origin_q[i]};
      end
    end
  end

  function automatic logic signed [32:0] sel_opnd(input opnd_e o);
    logic signed [32:0] v;
    case (o)
      OpD0:   v = {dir_q[0][31], dir_q[0]};
      OpD1:   v = {dir_q[1][31], dir_q[1]};
      OpD2:   v = {dir_q[2][31], dir_q[2]};
      OpW0:   v = w_q[0];
      OpW1:   v = w_q[1];
      OpW2:   v = w_q[2];
      OpR:    v = {2'b00, radius_q};
      OpALo:  v = {1'b0, a_q[31:0]};
      OpAHi:  v = {1'b0, a_q[63:32]};
      OpRLo:  v = {1'b0, rr_q[31:0]};
      OpRHi:  v = {1'b0, rr_q[63:32]};
      OpC0Lo: v = {1'b0, c_q[0][31:0]};
      OpC0Hi: v = c_q[0][64:32];
      OpC1Lo: v = {1'b0, c_q[1][31:0]};
      OpC1Hi: v = c_q[1][64:32];
      OpC2Lo: v = {1'b0, c_q[2][31:0]};
      OpC2Hi: v = c_q[2][64:32];
      default: v = '0;
    endcase
    return v;
  endfunction

  assign uop_cur = uop_at(cmd_i.step);

  always_comb begin
    opa = sel_opnd(uop_cur.opa);
    opb = sel_opnd(uop_cur.opb);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
    end else begin
      pvld_q <= cmd_i.mul_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_issue) begin
      prod_q <= opa * opb;
      uop_q  <= uop_cur;
    end
  end

  always_comb begin
    ext = AccW'(prod_q);
    case (uop_q.sh)
      Sh0:     term = ext;
      Sh32:    term = ext <<< 32;
      Sh33:    term = ext <<< 33;
      Sh64:    term = ext <<< 64;
      default: term = ext;
    endcase
    if (uop_q.neg) term = -term;
    acc_d = uop_q.first ? term : acc_q + term;
  end

  // Cross terms are kept signed: the high half of each is a signed digit.
  always_ff @(posedge clk_i) begin
    if (pvld_q) begin
      acc_q <= acc_d;
      case (uop_q.dst)
        DstA:    a_q    <= acc_d[63:0];
        DstRr:   rr_q   <= acc_d[63:0];
        DstC0:   c_q[0] <= acc_d[64:0];
        DstC1:   c_q[1] <= acc_d[64:0];
        DstC2:   c_q[2] <= acc_d[64:0];
        DstB:    b_q    <= acc_d[65:0];
        default: ;
      endcase
    end
  end

  // Two bits of the discriminant per step.
  always_comb begin
    sq_tmp   = {rem_q, rad_q[127:126]};
    sq_trial = {2'b00, root_q, 2'b01};
    sq_ge    = sq_tmp >= sq_trial;
  end

  always_comb begin
    n1   = {b_q[65], b_q} - {3'b000, root_q};
    n2   = {b_q[65], b_q} + {3'b000, root_q};
    pos1 = !n1[66] && (n1 != '0);
    pos2 = !n2[66] && (n2 != '0);
    nsel = pos1 ? n1 : n2;
    n_u  = nsel[65:0];
  end

  always_comb begin
    dv_tmp = {drem_q, dsh_q[30]};
    dv_a   = {1'b0, a_q};
    dv_ge  = dv_tmp >= dv_a;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      rad_q  <= acc_q[127:0];
      rem_q  <= '0;
      root_q <= '0;
      miss_q <= acc_q[AccW-1] || (a_q == '0);
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= {rad_q[125:0], 2'b00};
      rem_q  <= sq_ge ? 66'(sq_tmp - sq_trial) : sq_tmp[65:0];
      root_q <= {root_q[62:0], sq_ge};
    end else if (cmd_i.root) begin
      miss_q <= miss_q || !(pos1 || pos2);
      sat_q  <= {13'd0, n_u} >= {a_q, 15'd0};
      drem_q <= 64'(n_u >> 15);
      dsh_q  <= {n_u[14:0], 16'd0};
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      drem_q <= dv_ge ? 64'(dv_tmp - dv_a) : dv_tmp[63:0];
      dsh_q  <= {dsh_q[29:0], 1'b0};
      quo_q  <= {quo_q[29:0], dv_ge};
    end
  end

  assign sph_dist = sat_q ? DistSat : quo_q;
  assign cnt_full = cnt_q >= SphCntW'(MAX_SPHERES);

  assign sts_o.needs_solve = (mode_q == ModeSphere) && elig_q && !cnt_full;
  assign sts_o.last        = last_q;
  assign sts_o.out_busy    = res_valid_o;

  always_comb begin
    fin_hit = 1'b0;
    fin_chg = 1'b0;
    if (sel_en_i) begin
      if (found_q && (best_q <= {1'b0, max_dist_i})) begin
        fin_hit = 1'b1;
        fin_chg = !sel_valid_q || (sel_idx_q != best_idx_q);
      end else begin
        fin_chg = sel_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= '1;
      best_idx_q  <= '0;
      found_q     <= 1'b0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      sel_idx_q   <= '0;
      sel_valid_q <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        res_valid_o <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_o <= 1'b0;
      end
      if (cmd_i.book && (mode_q == ModeSphere)) begin
        if (cnt_full) begin
          ovf_q <= 1'b1;
        end else begin
          if (sts_o.needs_solve && !miss_q && ({1'b0, sph_dist} < best_q)) begin
            best_q     <= {1'b0, sph_dist};
            best_idx_q <= cnt_q[IdxW-1:0];
            found_q    <= 1'b1;
          end
          cnt_q <= cnt_q + SphCntW'(1);
        end
      end
      if (cmd_i.finish) begin
        if (sel_en_i) begin
          sel_valid_q <= fin_hit;
          sel_idx_q   <= fin_hit ? best_idx_q : '0;
        end
        best_q     <= '1;
        best_idx_q <= '0;
        found_q    <= 1'b0;
        cnt_q      <= '0;
        ovf_q      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      hit_o               <= fin_hit;
      hit_index_o         <= fin_hit ? 10'(best_idx_q) : 10'd0;
      distance_o          <= fin_hit ? best_q[30:0] : 31'd0;
      selection_changed_o <= fin_chg;
      overflow_o          <= ovf_q;
    end
  end

endmodule
